[src/mst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the multi-slot timer core.
// No dependencies; used by every module under src.
package mst_pkg;

  localparam int SLOTS      = 16;
  localparam int COUNT_BITS = 16;
  localparam int MASK_BITS  = 16;
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // one bit above both the index and the 4-bit slot field, so MASK_BITS fits
  localparam int CMP_W      = ((IDX_W > 4) ? IDX_W : 4) + 1;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_DELETE = 3'd2,
    OP_START  = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [15:0] initial_delay;
    logic [15:0] repeat_count;
    logic        start_running;
  } in_t;

  typedef struct packed {
    logic [3:0]  new_slot;
    logic        status;
    logic [15:0] fire_mask;
  } out_t;

  typedef struct packed {
    logic                  used;
    logic                  running;
    logic [COUNT_BITS-1:0] remaining;
    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] firings;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   we;
    logic   fire;
    logic   take;
    logic   del_hit;
  } alu_res_t;

endpackage

[src/mst_slot_table.sv]
`timescale 1ns / 1ps
// Per-slot timer state held in flops, read and written at the sweep index.
// Depends on mst_pkg.
module mst_slot_table (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [mst_pkg::IDX_W-1:0] idx_i,
  input  logic                    we_i,
  input  mst_pkg::entry_t         wr_i,
  output mst_pkg::entry_t         rd_o
);

  logic [mst_pkg::SLOTS-1:0]      used_q;
  logic [mst_pkg::SLOTS-1:0]      running_q;
  logic [mst_pkg::COUNT_BITS-1:0] remaining_q [mst_pkg::SLOTS];
  logic [mst_pkg::COUNT_BITS-1:0] reload_q    [mst_pkg::SLOTS];
  logic [mst_pkg::COUNT_BITS-1:0] firings_q   [mst_pkg::SLOTS];

  always_comb begin
    rd_o.used      = used_q[idx_i];
    rd_o.running   = running_q[idx_i];
    rd_o.remaining = remaining_q[idx_i];
    rd_o.reload    = reload_q[idx_i];
    rd_o.firings   = firings_q[idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      running_q <= '0;
      for (int i = 0; i < mst_pkg::SLOTS; i++) begin
        remaining_q[i] <= '0;
        reload_q[i]    <= '0;
        firings_q[i]   <= '0;
      end
    end else if (we_i) begin
      used_q[idx_i]      <= wr_i.used;
      running_q[idx_i]   <= wr_i.running;
      remaining_q[idx_i] <= wr_i.remaining;
      reload_q[idx_i]    <= wr_i.reload;
      firings_q[idx_i]   <= wr_i.firings;
    end
  end

endmodule

[src/mst_slot_alu.sv]
`timescale 1ns / 1ps
// Shared slot update unit: next state of one slot for the current operation.
// Depends on mst_pkg.
module mst_slot_alu (
  input  mst_pkg::in_t              req_i,
  input  logic [mst_pkg::IDX_W-1:0] idx_i,
  input  mst_pkg::entry_t           entry_i,
  input  logic                      found_i,
  output mst_pkg::alu_res_t         res_o
);

  logic slot_match;

  assign slot_match = (mst_pkg::CMP_W'(req_i.slot) == mst_pkg::CMP_W'(idx_i));

  always_comb begin
    res_o.entry   = entry_i;
    res_o.we      = 1'b0;
    res_o.fire    = 1'b0;
    res_o.take    = 1'b0;
    res_o.del_hit = 1'b0;
    case (req_i.func)
      mst_pkg::OP_TICK: begin
        res_o.we = 1'b1;
        if (entry_i.remaining != '0) begin
          res_o.entry.remaining = entry_i.remaining - 1'b1;
        end else if (entry_i.running && entry_i.used) begin
          res_o.fire = 1'b1;
          if (entry_i.firings == mst_pkg::COUNT_BITS'(1)) begin
            // last permitted firing: free the slot
            res_o.entry.used      = 1'b0;
            res_o.entry.running   = 1'b0;
            res_o.entry.remaining = '0;
            res_o.entry.firings   = '0;
          end else begin
            res_o.entry.remaining = entry_i.reload;
            if (entry_i.firings != '0) begin
              res_o.entry.firings = entry_i.firings - 1'b1;
            end
          end
        end
      end
      mst_pkg::OP_CREATE: begin
        if (!found_i && !entry_i.used) begin
          res_o.we              = 1'b1;
          res_o.take            = 1'b1;
          res_o.entry.used      = 1'b1;
          res_o.entry.running   = req_i.start_running;
          res_o.entry.remaining = mst_pkg::COUNT_BITS'(req_i.initial_delay);
          res_o.entry.reload    = mst_pkg::COUNT_BITS'(req_i.initial_delay);
          res_o.entry.firings   = mst_pkg::COUNT_BITS'(req_i.repeat_count);
        end
      end
      mst_pkg::OP_DELETE: begin
        if (slot_match && entry_i.used) begin
          // keep the reload value
          res_o.we              = 1'b1;
          res_o.del_hit         = 1'b1;
          res_o.entry.used      = 1'b0;
          res_o.entry.running   = 1'b0;
          res_o.entry.remaining = '0;
          res_o.entry.firings   = '0;
        end
      end
      mst_pkg::OP_START: begin
        if (slot_match) begin
          res_o.we            = 1'b1;
          res_o.entry.running = 1'b1;
        end
      end
      mst_pkg::OP_STOP: begin
        if (slot_match) begin
          res_o.we            = 1'b1;
          res_o.entry.running = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/multi_slot_software_timer_core.sv]
`timescale 1ns / 1ps
// Multi-slot timer core: every operation sweeps the slot table, one slot per cycle.
// ST_DONE loads the result into the output register once the sweep has visited all slots.
// A new beat is taken only in ST_IDLE, as the single shared slot update unit runs one sweep.
// A finished result waits in the output register; a new beat is taken meanwhile.
// Reset (async, active low): all slots free, stopped and zeroed; no result pending.
// Depends on mst_pkg, mst_slot_table and mst_slot_alu.
module multi_slot_software_timer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mst_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mst_pkg::out_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e                      state_q;
  logic [mst_pkg::IDX_W-1:0]   idx_q;
  mst_pkg::in_t                req_q;
  logic                        found_q;
  logic                        hit_q;
  logic [mst_pkg::MASK_BITS-1:0] fire_q;
  logic [3:0]                  new_slot_q;
  logic                        out_valid_q;
  mst_pkg::out_t               out_data_q;

  mst_pkg::entry_t             rd_entry;
  mst_pkg::alu_res_t           alu_res;
  logic [mst_pkg::CMP_W-1:0]   idx_ext;
  logic                        last_idx;
  logic                        table_we;
  mst_pkg::out_t               result;

  assign idx_ext    = mst_pkg::CMP_W'(idx_q);
  assign last_idx   = (idx_q == mst_pkg::IDX_W'(mst_pkg::SLOTS - 1));
  assign table_we   = (state_q == ST_SWEEP) && alu_res.we;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    result.new_slot  = new_slot_q;
    result.fire_mask = fire_q;
    result.status    = ((req_q.func == mst_pkg::OP_CREATE) && !found_q) ||
                       ((req_q.func == mst_pkg::OP_DELETE) && !hit_q);
  end

  mst_slot_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_q),
    .we_i   (table_we),
    .wr_i   (alu_res.entry),
    .rd_o   (rd_entry)
  );

  mst_slot_alu u_alu (
    .req_i   (req_q),
    .idx_i   (idx_q),
    .entry_i (rd_entry),
    .found_i (found_q),
    .res_o   (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      req_q       <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      fire_q      <= '0;
      new_slot_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // load the next result when the register is free, else drop a taken beat
      if ((state_q == ST_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_data_q  <= result;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q      <= in_data_i;
            idx_q      <= '0;
            found_q    <= 1'b0;
            hit_q      <= 1'b0;
            fire_q     <= '0;
            new_slot_q <= '0;
            state_q    <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (alu_res.take) begin
            found_q    <= 1'b1;
            new_slot_q <= idx_ext[3:0];
          end
          if (alu_res.del_hit) begin
            hit_q <= 1'b1;
          end
          // slots beyond the mask width fire silently
          if (alu_res.fire && (idx_ext < mst_pkg::CMP_W'(mst_pkg::MASK_BITS))) begin
            fire_q[idx_ext[3:0]] <= 1'b1;
          end
          if (last_idx) begin
            state_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SWEEP) && (idx_q == '0))
    else $error("sweep did not start at slot 0 after an accepted beat");

  a_sweep_runs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && !last_idx) |=> (state_q == ST_SWEEP))
    else $error("sweep left before the last slot");

  a_fire_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && alu_res.fire) |-> (req_q.func == mst_pkg::OP_TICK))
    else $error("slot fired outside a tick");

  a_new_slot_only_create: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && req_q.func != mst_pkg::OP_CREATE) |->
      (result.new_slot == '0))
    else $error("new slot reported for an operation other than create");

  a_no_fail_with_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && result.status) |-> (result.fire_mask == '0))
    else $error("failed status carries a fire mask");
`endif

endmodule
